// ----- rtl/core/cfp_pkg.sv -----
// Package for the control frame parser core.
// Holds the frame constants, the parse phase type and the token and result types.
// Depends on nothing.
`default_nettype none

package cfp_pkg;

    localparam logic [7:0] SOF_FIRST     = 8'h24;
    localparam logic [7:0] SOF_SECOND    = 8'h70;
    localparam logic [7:0] SOF_SUM       = SOF_FIRST + SOF_SECOND;
    localparam logic [3:0] PAYLOAD_FIRST = 4'd2;
    localparam logic [3:0] CKSUM_POS     = 4'd11;
    localparam int         PAYLOAD_LEN   = 9;

    typedef enum logic [1:0] {
        PH_HUNT_EMPTY = 2'd0,
        PH_HUNT_ONE   = 2'd1,
        PH_COLLECT    = 2'd2
    } cfp_phase_t;

    typedef struct packed {
        logic       commit;
        logic [3:0] slot;
        logic [7:0] data;
    } cfp_token_t;

    typedef struct packed {
        logic [3:0]  robot_mode;
        logic        enabled;
        logic        estopped;
        logic [15:0] buttons;
        logic [7:0]  axis_left_x;
        logic [7:0]  axis_left_y;
        logic [7:0]  axis_right_x;
        logic [7:0]  axis_right_y;
        logic [7:0]  axis_trigger_x;
        logic [7:0]  axis_trigger_y;
    } cfp_result_t;

endpackage

`default_nettype wire

// ----- rtl/core/cfp_fifo.sv -----
// Small register queue used between the parser stages and on the result side.
// Depends on nothing; width and depth come from parameters.
`default_nettype none

module cfp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    output logic      [WIDTH-1:0] rd_data,
    output logic                  full,
    output logic                  empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/cfp_front.sv -----
// Front stage: hunts for the start pattern, tracks the frame position and the checksum.
// Emits payload and commit tokens. Depends on cfp_pkg.
`default_nettype none

module cfp_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_accept,
    input  wire logic [7:0]        rx_byte,
    output logic                   tok_push,
    output cfp_pkg::cfp_token_t    tok
);

    import cfp_pkg::*;

    cfp_phase_t phase_reg, phase_next;
    logic [7:0] prev_byte_reg, prev_byte_next;
    logic [3:0] index_reg, index_next;
    logic [7:0] sum_reg, sum_next;

    always_comb
    begin
        phase_next     = phase_reg;
        prev_byte_next = prev_byte_reg;
        index_next     = index_reg;
        sum_next       = sum_reg;
        if (in_accept)
        begin
            unique case (phase_reg)
                PH_COLLECT:
                begin
                    if (index_reg < CKSUM_POS)
                    begin
                        sum_next   = sum_reg + rx_byte;
                        index_next = index_reg + 4'd1;
                    end
                    else
                    begin
                        phase_next = PH_HUNT_EMPTY;
                        index_next = '0;
                        sum_next   = '0;
                    end
                end
                default:
                begin
                    if (phase_reg == PH_HUNT_ONE && prev_byte_reg == SOF_FIRST
                        && rx_byte == SOF_SECOND)
                    begin
                        phase_next = PH_COLLECT;
                        index_next = PAYLOAD_FIRST;
                        sum_next   = SOF_SUM;
                    end
                    else
                    begin
                        phase_next     = PH_HUNT_ONE;
                        prev_byte_next = rx_byte;
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        tok_push   = 1'b0;
        tok.commit = 1'b0;
        tok.slot   = index_reg - PAYLOAD_FIRST;
        tok.data   = rx_byte;
        if (in_accept && phase_reg == PH_COLLECT)
        begin
            if (index_reg < CKSUM_POS)
            begin
                tok_push = (index_reg >= PAYLOAD_FIRST);
            end
            else
            begin
                tok.commit = 1'b1;
                tok_push   = (rx_byte == sum_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HUNT_EMPTY;
            prev_byte_reg <= '0;
            index_reg     <= '0;
            sum_reg       <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            prev_byte_reg <= prev_byte_next;
            index_reg     <= index_next;
            sum_reg       <= sum_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/cfp_back.sv -----
// Back stage: stores payload bytes and builds a result when a commit token arrives.
// Depends on cfp_pkg.
`default_nettype none

module cfp_back (
    input  wire logic                  clk,
    input  wire logic                  tok_empty,
    input  wire cfp_pkg::cfp_token_t   tok,
    output logic                       tok_pop,
    input  wire logic                  res_full,
    output logic                       res_push,
    output cfp_pkg::cfp_result_t       res
);

    import cfp_pkg::*;

    logic [7:0] store_reg [PAYLOAD_LEN];

    always_comb
    begin
        tok_pop  = 1'b0;
        res_push = 1'b0;
        if (!tok_empty)
        begin
            if (tok.commit)
            begin
                tok_pop  = !res_full;
                res_push = !res_full;
            end
            else
            begin
                tok_pop = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tok_pop && !tok.commit && tok.slot < 4'(PAYLOAD_LEN))
        begin
            store_reg[tok.slot] <= tok.data;
        end
    end

    assign res.robot_mode     = store_reg[0][3:0];
    assign res.enabled        = store_reg[0][4];
    assign res.estopped       = store_reg[0][5];
    assign res.buttons        = {store_reg[2], store_reg[1]};
    assign res.axis_left_x    = store_reg[3];
    assign res.axis_left_y    = store_reg[4];
    assign res.axis_right_x   = store_reg[5];
    assign res.axis_right_y   = store_reg[6];
    assign res.axis_trigger_x = store_reg[7];
    assign res.axis_trigger_y = store_reg[8];

endmodule

`default_nettype wire

// ----- rtl/core/control_frame_parser_core.sv -----
// Top level of the control frame parser: front stage, token queue, back stage, result queue.
// Depends on cfp_pkg, cfp_fifo, cfp_front and cfp_back.
//
//   channel   direction  handshake      payload
//   input     in         push / full    rx_byte
//   result    out        empty / pop    robot_mode .. axis_trigger_y
//
// One byte is accepted per cycle while full is low; a good frame's commit token passes through
// the token queue, and once the result queue has room its result is written there to be popped.
// Reset clears the parse state and both queues; the payload store is not reset.
// full rises only when the token queue fills, which happens after the result queue fills
// and a commit waits; payload bytes keep flowing while a result waits to be taken.
`default_nettype none

module control_frame_parser_core #(
    parameter int TOKEN_DEPTH  = 4,
    parameter int RESULT_DEPTH = 2
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  rx_byte,
    output logic             empty,
    input  wire logic        pop,
    output logic [3:0]       robot_mode,
    output logic             enabled,
    output logic             estopped,
    output logic [15:0]      buttons,
    output logic [7:0]       axis_left_x,
    output logic [7:0]       axis_left_y,
    output logic [7:0]       axis_right_x,
    output logic [7:0]       axis_right_y,
    output logic [7:0]       axis_trigger_x,
    output logic [7:0]       axis_trigger_y
);

    import cfp_pkg::*;

    logic        in_accept;
    logic        tok_push, tok_pop, tok_full, tok_empty;
    cfp_token_t  tok_in, tok_out;
    logic        res_push, res_full;
    cfp_result_t res_in, res_out;

    assign full      = tok_full;
    assign in_accept = push && !tok_full;

    cfp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_accept (in_accept),
        .rx_byte   (rx_byte),
        .tok_push  (tok_push),
        .tok       (tok_in)
    );

    cfp_fifo #(
        .WIDTH ($bits(cfp_token_t)),
        .DEPTH (TOKEN_DEPTH)
    ) u_tok_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (tok_push),
        .wr_data (tok_in),
        .rd_en   (tok_pop),
        .rd_data (tok_out),
        .full    (tok_full),
        .empty   (tok_empty)
    );

    cfp_back u_back (
        .clk       (clk),
        .tok_empty (tok_empty),
        .tok       (tok_out),
        .tok_pop   (tok_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res_in)
    );

    cfp_fifo #(
        .WIDTH ($bits(cfp_result_t)),
        .DEPTH (RESULT_DEPTH)
    ) u_res_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_in),
        .rd_en   (pop),
        .rd_data (res_out),
        .full    (res_full),
        .empty   (empty)
    );

    assign robot_mode     = res_out.robot_mode;
    assign enabled        = res_out.enabled;
    assign estopped       = res_out.estopped;
    assign buttons        = res_out.buttons;
    assign axis_left_x    = res_out.axis_left_x;
    assign axis_left_y    = res_out.axis_left_y;
    assign axis_right_x   = res_out.axis_right_x;
    assign axis_right_y   = res_out.axis_right_y;
    assign axis_trigger_x = res_out.axis_trigger_x;
    assign axis_trigger_y = res_out.axis_trigger_y;

`ifndef NO_ASSERTIONS
    a_tok_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        tok_push |-> !tok_full)
        else $error("Token queue written while full.");

    a_res_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("Result queue written while full.");

    a_commit_pairs_result: assert property (@(posedge clk) disable iff (!rst_n)
        (tok_pop && tok_out.commit) |-> res_push)
        else $error("Commit token retired without a result transaction.");

    a_no_result_without_commit: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> (!tok_empty && tok_out.commit))
        else $error("Result transaction without a commit token.");
`endif

endmodule

`default_nettype wire
